// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/gdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int SYEAR_W = 15;   // year plus one 400-year cycle
  localparam int LEN_W   = 5;
  localparam int WD_W    = 3;
  localparam int YDAY_W  = 9;
  localparam int MWEEK_W = 3;
  localparam int YWEEK_W = 6;
  localparam int DIFF_W  = 23;
  localparam int SER_W   = 23;   // day serial, unsigned
  localparam int LEAPS_W = 13;
  localparam int WSUM_W  = 15;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [WD_W-1:0]    ISO_SUNDAY = 3'd7;

  localparam logic [SYEAR_W-1:0] YEAR_SHIFT = 15'd400;

  // floor(x / 100) as floor(floor(x / 4) / 25), reciprocal 1311 / 2^15
  function automatic logic [7:0] div100(input logic [SYEAR_W-1:0] x);
    logic [23:0] p;
    p = 24'(x[SYEAR_W-1:2]) * 24'd1311;
    return p[22:15];
  endfunction

  // floor(x / 7), reciprocal 74899 / 2^19, exact for every 15-bit x
  function automatic logic [12:0] div7(input logic [WSUM_W-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'd74899;
    return p[31:19];
  endfunction

  // q is floor(y / 100)
  function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [7:0] q);
    logic [YEAR_W-1:0] h;
    h = YEAR_W'(q) * 14'd100;
    return (y[1:0] == 2'd0) && ((h != y) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [WD_W-1:0] sak_off(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    return 3'd0;
      4'd2:    return 3'd3;
      4'd3:    return 3'd2;
      4'd4:    return 3'd5;
      4'd5:    return 3'd0;
      4'd6:    return 3'd3;
      4'd7:    return 3'd5;
      4'd8:    return 3'd1;
      4'd9:    return 3'd4;
      4'd10:   return 3'd6;
      4'd11:   return 3'd2;
      4'd12:   return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  // days before the month in a common year
  function automatic logic [YDAY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] mon_len(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:    return leap ? 5'd29 : 5'd28;
      default: return 5'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gdc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gdc_in_if import gdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_a;
  logic [MONTH_W-1:0] month_a;
  logic [DAY_W-1:0]   day_a;
  logic [YEAR_W-1:0]  year_b;
  logic [MONTH_W-1:0] month_b;
  logic [DAY_W-1:0]   day_b;

  modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  input ready);
  modport sink   (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  output ready);
endinterface

interface gdc_out_if import gdc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     date_valid;
  logic                     leap_year;
  logic [LEN_W-1:0]         month_length;
  logic [WD_W-1:0]          weekday_sunday_zero;
  logic [WD_W-1:0]          weekday_iso;
  logic [YDAY_W-1:0]        year_day;
  logic [MWEEK_W-1:0]       month_week;
  logic [YWEEK_W-1:0]       year_week;
  logic signed [DIFF_W-1:0] day_difference;

  modport source (output valid, date_valid, leap_year, month_length, weekday_sunday_zero,
                  weekday_iso, year_day, month_week, year_week, day_difference,
                  input ready);
  modport sink   (input valid, date_valid, leap_year, month_length, weekday_sunday_zero,
                  weekday_iso, year_day, month_week, year_week, day_difference,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gregorian_date_calculator.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
//
// Channel   Dir  Beat
// in_ch     in   two dates A and B (year, month, day each)
// out_ch    out  calendar facts of A and signed day count B - A
//
// Four register stages: year split and /100, leap and validity, weekday mod 7
// and day serials, ISO weekday, weeks and difference. One beat per cycle
// while the output is not held by back-pressure.
// Each stage advances when it is empty or the next one moves, so bubbles
// close up under back-pressure. Reset clears only the stage valid bits.
//
module gregorian_date_calculator
  import gdc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  gdc_in_if.sink      in_ch,
  gdc_out_if.source   out_ch
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_ch.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // ---------------- stage 1: shifted year and divisions by 100
  logic [YEAR_W-1:0]  ya_r, yb_r;
  logic [MONTH_W-1:0] ma_r, mb_r;
  logic [DAY_W-1:0]   da_r, db_r;
  logic [SYEAR_W-1:0] sa_r, sb_r, sa_nxt, sb_nxt;
  logic [7:0]         qsa_r, qsb_r, qya_r, qyb_r;

  assign sa_nxt = {1'b0, in_ch.year_a} + YEAR_SHIFT
                - SYEAR_W'(in_ch.month_a < MONTH_MAR);
  assign sb_nxt = {1'b0, in_ch.year_b} + YEAR_SHIFT
                - SYEAR_W'(in_ch.month_b < MONTH_MAR);

  always_ff @(posedge clk) begin
    if (adv1) begin
      ya_r  <= in_ch.year_a;
      ma_r  <= in_ch.month_a;
      da_r  <= in_ch.day_a;
      yb_r  <= in_ch.year_b;
      mb_r  <= in_ch.month_b;
      db_r  <= in_ch.day_b;
      sa_r  <= sa_nxt;
      sb_r  <= sb_nxt;
      qsa_r <= div100(sa_nxt);
      qsb_r <= div100(sb_nxt);
      qya_r <= div100({1'b0, in_ch.year_a});
      qyb_r <= div100({1'b0, in_ch.year_b});
    end
  end

  // ---------------- stage 2: leap, month length, validity, weekday sum
  logic               leap_a, leap_b;
  logic [LEN_W-1:0]   len_a, len_b;
  logic               va_nxt, vb_nxt;
  logic [LEAPS_W-1:0] leaps_a_nxt, leaps_b_nxt;
  logic [WSUM_W-1:0]  wsum_nxt;
  logic [YDAY_W-1:0]  yd_nxt, offa_nxt, offb_nxt;

  assign leap_a = is_leap(ya_r, qya_r);
  assign leap_b = is_leap(yb_r, qyb_r);
  assign len_a  = mon_len(ma_r, leap_a);
  assign len_b  = mon_len(mb_r, leap_b);
  assign va_nxt = (da_r != '0) && (da_r <= len_a);
  assign vb_nxt = (db_r != '0) && (db_r <= len_b);

  // leap days: s/4 - s/100 + s/400
  assign leaps_a_nxt = sa_r[SYEAR_W-1:2] - LEAPS_W'(qsa_r) + LEAPS_W'(qsa_r[7:2]);
  assign leaps_b_nxt = sb_r[SYEAR_W-1:2] - LEAPS_W'(qsb_r) + LEAPS_W'(qsb_r[7:2]);

  assign wsum_nxt = sa_r + WSUM_W'(leaps_a_nxt) + WSUM_W'(sak_off(ma_r)) + WSUM_W'(da_r);
  assign offa_nxt = cum_days(ma_r) + YDAY_W'(da_r);
  assign offb_nxt = cum_days(mb_r) + YDAY_W'(db_r);
  assign yd_nxt   = offa_nxt + YDAY_W'(leap_a && (ma_r > MONTH_FEB));

  logic [YEAR_W-1:0]  s2_ya_r, s2_yb_r;
  logic [DAY_W-1:0]   s2_da_r;
  logic               s2_leap_r, s2_va_r, s2_vb_r;
  logic [LEN_W-1:0]   s2_len_r;
  logic [LEAPS_W-1:0] s2_leaps_a_r, s2_leaps_b_r;
  logic [WSUM_W-1:0]  s2_wsum_r;
  logic [YDAY_W-1:0]  s2_yd_r, s2_offa_r, s2_offb_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_ya_r      <= ya_r;
      s2_yb_r      <= yb_r;
      s2_da_r      <= da_r;
      s2_leap_r    <= leap_a;
      s2_va_r      <= va_nxt;
      s2_vb_r      <= vb_nxt;
      s2_len_r     <= len_a;
      s2_leaps_a_r <= leaps_a_nxt;
      s2_leaps_b_r <= leaps_b_nxt;
      s2_wsum_r    <= wsum_nxt;
      s2_yd_r      <= yd_nxt;
      s2_offa_r    <= offa_nxt;
      s2_offb_r    <= offb_nxt;
    end
  end

  // ---------------- stage 3: weekday mod 7, day serials
  logic [12:0]       wq;
  logic [WSUM_W-1:0] wrem;
  logic [SER_W-1:0]  sera_nxt, serb_nxt;

  assign wq   = div7(s2_wsum_r);
  assign wrem = s2_wsum_r - WSUM_W'(wq) * WSUM_W'(7);

  assign sera_nxt = SER_W'({1'b0, s2_ya_r} + YEAR_SHIFT) * SER_W'(365)
                  + SER_W'(s2_leaps_a_r) + SER_W'(s2_offa_r);
  assign serb_nxt = SER_W'({1'b0, s2_yb_r} + YEAR_SHIFT) * SER_W'(365)
                  + SER_W'(s2_leaps_b_r) + SER_W'(s2_offb_r);

  logic [WD_W-1:0]   s3_wd_r;
  logic [SER_W-1:0]  s3_sera_r, s3_serb_r;
  logic [DAY_W-1:0]  s3_da_r;
  logic              s3_leap_r, s3_va_r, s3_vb_r;
  logic [LEN_W-1:0]  s3_len_r;
  logic [YDAY_W-1:0] s3_yd_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_wd_r   <= wrem[WD_W-1:0];
      s3_sera_r <= sera_nxt;
      s3_serb_r <= serb_nxt;
      s3_da_r   <= s2_da_r;
      s3_leap_r <= s2_leap_r;
      s3_va_r   <= s2_va_r;
      s3_vb_r   <= s2_vb_r;
      s3_len_r  <= s2_len_r;
      s3_yd_r   <= s2_yd_r;
    end
  end

  // ---------------- stage 4: ISO weekday, weeks, difference
  logic [WD_W-1:0]          iso_nxt;
  logic [12:0]              mwq, ywq;
  logic signed [SER_W:0]    diff_wide;
  logic signed [DIFF_W-1:0] diff_nxt;

  assign iso_nxt = (s3_wd_r == '0) ? ISO_SUNDAY : s3_wd_r;
  assign mwq = div7(WSUM_W'(s3_da_r) + WSUM_W'(10) - WSUM_W'(iso_nxt));
  assign ywq = div7(WSUM_W'(s3_yd_r) + WSUM_W'(10) - WSUM_W'(iso_nxt));

  assign diff_wide = $signed({1'b0, s3_serb_r}) - $signed({1'b0, s3_sera_r});

  always_comb begin
    if (diff_wide[SER_W] != diff_wide[SER_W-1]) begin
      // saturate to the 23-bit range
      diff_nxt = diff_wide[SER_W] ? {1'b1, {(DIFF_W-1){1'b0}}} : {1'b0, {(DIFF_W-1){1'b1}}};
    end else begin
      diff_nxt = diff_wide[DIFF_W-1:0];
    end
  end

  logic                     o_va_r, o_leap_r;
  logic [LEN_W-1:0]         o_len_r;
  logic [WD_W-1:0]          o_wd_r, o_iso_r;
  logic [YDAY_W-1:0]        o_yd_r;
  logic [MWEEK_W-1:0]       o_mw_r;
  logic [YWEEK_W-1:0]       o_yw_r;
  logic signed [DIFF_W-1:0] o_diff_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      o_va_r   <= s3_va_r;
      o_leap_r <= s3_leap_r;
      o_len_r  <= s3_len_r;
      o_wd_r   <= s3_va_r ? s3_wd_r : '0;
      o_iso_r  <= s3_va_r ? iso_nxt : '0;
      o_yd_r   <= s3_va_r ? s3_yd_r : '0;
      o_mw_r   <= s3_va_r ? mwq[MWEEK_W-1:0] : '0;
      o_yw_r   <= s3_va_r ? ywq[YWEEK_W-1:0] : '0;
      o_diff_r <= (s3_va_r && s3_vb_r) ? diff_nxt : '0;
    end
  end

  assign out_ch.valid               = v4_r;
  assign out_ch.date_valid          = o_va_r;
  assign out_ch.leap_year           = o_leap_r;
  assign out_ch.month_length        = o_len_r;
  assign out_ch.weekday_sunday_zero = o_wd_r;
  assign out_ch.weekday_iso         = o_iso_r;
  assign out_ch.year_day            = o_yd_r;
  assign out_ch.month_week          = o_mw_r;
  assign out_ch.year_week           = o_yw_r;
  assign out_ch.day_difference      = o_diff_r;

  // ---------------- checks
  `ASSERT_NEXT(a_enter_s1, clk, rst_n, in_ch.valid && in_ch.ready, v1_r)
  `ASSERT_IMPL(a_full_stall, clk, rst_n, v1_r && v2_r && v3_r && v4_r && !out_ch.ready, !in_ch.ready)
  `ASSERT_IMPL(a_invalid_zero, clk, rst_n, v4_r && !o_va_r, (o_iso_r == '0) && (o_yd_r == '0) && (o_diff_r == '0))
  `ASSERT_IMPL(a_iso_match, clk, rst_n, v4_r && o_va_r, ((o_iso_r == ISO_SUNDAY) && (o_wd_r == '0)) || ((o_iso_r != '0) && (o_iso_r == o_wd_r)))
  `ASSERT_IMPL(a_yday_range, clk, rst_n, v4_r && o_va_r, (o_yd_r != '0) && (o_yd_r <= 9'd366))

endmodule

`default_nettype wire
